@@ rtl/lqmq_pkg.sv @@
// Package for the linear queue with maximum query.
// Holds widths, mode and status codes, and the controller/datapath structs.
// No dependencies.
package lqmq_pkg;

  localparam int DATA_W        = 32;
  localparam int COUNT_W       = 8;
  localparam int DEPTH_DEFAULT = 128;

  // Request modes
  localparam logic MODE_PUSH = 1'b0;
  localparam logic MODE_POP  = 1'b1;

  // Result status codes
  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic accept;     // request item taken this cycle
    logic pop_load;   // capture popped entry, retire head
    logic load_scan;  // set up scan pointer, count and max
    logic issue;      // read store at scan pointer
    logic load_out;   // move result into the output register
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic nonempty;
    logic ptr_at_tail;
    logic out_free;
  } sts_t;

endpackage

@@ rtl/lqmq_if.sv @@
// Request and result channel interfaces for the linear queue with maximum query.
// Depends on lqmq_pkg.
interface lqmq_req_if;
  import lqmq_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     mode;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, mode, value, input ready);
  modport sink   (input valid, mode, value, output ready);
endinterface

interface lqmq_rsp_if;
  import lqmq_pkg::*;

  logic                     valid;
  logic                     ready;
  status_t                  status;
  logic signed [DATA_W-1:0] popped_value;
  logic signed [DATA_W-1:0] max_value;
  logic                     max_valid;
  logic [COUNT_W-1:0]       entry_count;

  modport source (output valid, status, popped_value, max_value, max_valid, entry_count,
                  input ready);
  modport sink   (input valid, status, popped_value, max_value, max_valid, entry_count,
                  output ready);
endinterface

@@ rtl/linear_queue_with_max_query.sv @@
// Top level of the linear queue with maximum query.
// Joins controller and datapath. Depends on lqmq_pkg, lqmq_if, lqmq_ctrl, lqmq_dp.
//
// Usage:
//   req channel: valid/ready with mode (0 push value at tail, 1 pop from head)
//   and a signed 32-bit value. rsp channel: valid/ready with status, popped
//   value, maximum of the held entries, max_valid and entry count.
//   The queue is linear: a push is refused as full once the tail sits in the
//   last slot, even when the head has moved on. A pop of the last entry
//   returns both indices to slot 0.
//   Each item yields exactly one result. One item is worked on at a time:
//   the time from accept to result valid grows with the number of entries
//   held after the operation, as it is set by the max scan, which reads the
//   entry store through its single read port one entry per cycle.
//   A finished result waits in the output register; while it waits, the
//   next item is accepted and worked on, and its result is held back until
//   the receiver takes the earlier one.
//   Reset (rst, synchronous, active high) empties the queue and drops any
//   pending result; the store contents are not cleared and need no sweep.
module linear_queue_with_max_query #(
  parameter int DEPTH = lqmq_pkg::DEPTH_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  lqmq_req_if.sink   req,
  lqmq_rsp_if.source rsp
);
  import lqmq_pkg::*;

  cmd_t cmd;
  sts_t sts;

  lqmq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_pop   (req.mode == MODE_POP),
    .req_ready (req.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  lqmq_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .req_mode  (req.mode),
    .req_value (req.value),
    .cmd       (cmd),
    .sts       (sts),
    .rsp       (rsp)
  );

`ifndef SYNTHESIS
  // One item in work at a time
  assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> !req.ready)
    else $error("request accepted while an item is in work");

  // Empty queue reports zero max and zero count
  assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.max_valid |-> rsp.max_value == 0 && rsp.entry_count == 0)
    else $error("empty queue result carries max or count");

  // Refused pop leaves the queue empty
  assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.status == ST_EMPTY |-> !rsp.max_valid)
    else $error("refused pop on a nonempty queue");

  // Only a completed operation can carry a popped value
  assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.status != ST_DONE |-> rsp.popped_value == 0)
    else $error("refused item carries a popped value");
`endif

endmodule

@@ rtl/lqmq_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lqmq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

@@ rtl/lqmq_ctrl.sv @@
// Controller state machine for the linear queue with maximum query.
// Sequences accept, pop read, max scan and result hand-off. Depends on lqmq_pkg.
module lqmq_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  input  logic          req_pop,
  output logic          req_ready,
  input  lqmq_pkg::sts_t sts,
  output lqmq_pkg::cmd_t cmd
);
  import lqmq_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_POP,
    S_LOAD,
    S_SCAN,
    S_DRAIN,
    S_DONE
  } state_t;

  state_t state;
  state_t state_next;

  assign req_ready = (state == S_IDLE);

  // Decode commands and next state
  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.accept = 1'b1;
          state_next = (req_pop && sts.nonempty) ? S_POP : S_LOAD;
        end
      end
      S_POP: begin
        cmd.pop_load = 1'b1;
        state_next   = S_LOAD;
      end
      S_LOAD: begin
        cmd.load_scan = 1'b1;
        state_next    = sts.nonempty ? S_SCAN : S_DONE;
      end
      S_SCAN: begin
        cmd.issue = 1'b1;
        if (sts.ptr_at_tail) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_next = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Hold state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

@@ rtl/lqmq_dp.sv @@
// Datapath for the linear queue with maximum query: indices, entry store,
// scan pointer, running maximum and output register. Depends on lqmq_pkg, lqmq_ram.
module lqmq_dp #(
  parameter int DEPTH = lqmq_pkg::DEPTH_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              req_mode,
  input  logic signed [lqmq_pkg::DATA_W-1:0] req_value,
  input  lqmq_pkg::cmd_t                    cmd,
  output lqmq_pkg::sts_t                    sts,
  lqmq_rsp_if.source                        rsp
);
  import lqmq_pkg::*;

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [IDX_W-1:0]         head;
  logic [IDX_W-1:0]         tail;
  logic                     nonempty;
  logic [IDX_W-1:0]         ptr;
  logic                     pend;
  logic                     first;
  logic signed [DATA_W-1:0] best;
  status_t                  res_status;
  logic signed [DATA_W-1:0] res_popped;
  logic [COUNT_W-1:0]       res_count;
  logic                     out_valid;

  logic                     tail_last;
  logic                     wr_en;
  logic [IDX_W-1:0]         wr_addr;
  logic [IDX_W-1:0]         rd_addr;
  logic [DATA_W-1:0]        rd_data;
  logic [CNT_W-1:0]         held;

  assign tail_last = (tail == IDX_W'(DEPTH - 1));
  assign held      = CNT_W'(tail) - CNT_W'(head) + CNT_W'(1);

  // Write a pushed item at slot 0 or behind the tail
  assign wr_en   = cmd.accept && (req_mode == MODE_PUSH) && (!nonempty || !tail_last);
  assign wr_addr = nonempty ? tail + 1'b1 : '0;
  // Read the head for a pop, the scan pointer during the scan
  assign rd_addr = cmd.issue ? ptr : head;

  lqmq_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (req_value),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign sts.nonempty    = nonempty;
  assign sts.ptr_at_tail = (ptr == tail);
  assign sts.out_free    = !out_valid || rsp.ready;

  // Update queue indices
  always_ff @(posedge clk) begin
    if (rst) begin
      head     <= '0;
      tail     <= '0;
      nonempty <= 1'b0;
    end else if (wr_en) begin
      if (!nonempty) begin
        head     <= '0;
        tail     <= '0;
        nonempty <= 1'b1;
      end else begin
        tail <= tail + 1'b1;
      end
    end else if (cmd.pop_load) begin
      if (head == tail) begin
        head     <= '0;
        tail     <= '0;
        nonempty <= 1'b0;
      end else begin
        head <= head + 1'b1;
      end
    end
  end

  // Record status and popped value
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      res_popped <= '0;
      if (req_mode == MODE_PUSH) begin
        res_status <= (nonempty && tail_last) ? ST_FULL : ST_DONE;
      end else begin
        res_status <= nonempty ? ST_DONE : ST_EMPTY;
      end
    end else if (cmd.pop_load) begin
      res_popped <= $signed(rd_data);
    end
  end

  // Scan from head to tail, keeping the running maximum
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
    end else begin
      pend <= cmd.issue;
    end
    if (cmd.load_scan) begin
      ptr       <= head;
      first     <= 1'b1;
      best      <= '0;
      res_count <= nonempty ? COUNT_W'(held) : '0;
    end else begin
      if (cmd.issue && (ptr != tail)) begin
        ptr <= ptr + 1'b1;
      end
      if (pend) begin
        first <= 1'b0;
        if (first || ($signed(rd_data) > best)) begin
          best <= $signed(rd_data);
        end
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
    if (cmd.load_out) begin
      rsp.status       <= res_status;
      rsp.popped_value <= res_popped;
      rsp.max_value    <= best;
      rsp.max_valid    <= nonempty;
      rsp.entry_count  <= res_count;
    end
  end

  assign rsp.valid = out_valid;

endmodule

@@ tb/tb.sv @@
// Testbench for linear_queue_with_max_query: random and directed push/pop traffic.
// Checks every result against an in-bench queue model with a head-to-tail max scan.
// Depends on lqmq_pkg, lqmq_if and the RTL of the queue.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lqmq_pkg::*;

  localparam int DEPTH        = DEPTH_DEFAULT;
  localparam int QUIET_ITEMS  = 60;    // last items sent with no idling on either side
  localparam int PRESSURE_AT  = 60;    // accepted items before the long receiver hold
  localparam int HOLD_CYCLES  = 400;
  localparam int IDLE_LIMIT   = 4000;  // cycles with no item moving before giving up
  localparam int DRAIN_CYCLES = 300;
  localparam int SHOWN_ERRORS = 10;

  typedef struct {
    logic                     mode;
    logic signed [DATA_W-1:0] value;
  } queue_req_t;

  typedef struct {
    status_t                  status;
    logic signed [DATA_W-1:0] popped;
    logic signed [DATA_W-1:0] max_value;
    logic                     max_valid;
    logic [COUNT_W-1:0]       count;
  } queue_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  lqmq_req_if req_ch ();
  lqmq_rsp_if rsp_ch ();

  linear_queue_with_max_query #(.DEPTH(DEPTH)) DUT (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  always #5 clk = ~clk;

  // Queue model state
  logic signed [DATA_W-1:0] model_store [DEPTH];
  int                       model_head     = 0;
  int                       model_tail     = 0;
  bit                       model_nonempty = 1'b0;

  queue_req_t    pending_reqs[$];
  queue_result_t expected_results[$];
  queue_req_t    next_req;

  bit req_taken     = 1'b0;
  int req_accepted  = 0;
  int mismatches    = 0;
  int idle_cycles   = 0;
  int send_gap      = 0;
  int stall_left    = 0;
  int hold_left     = 0;
  bit hold_done     = 1'b0;

  // Apply one request to the model and return the result it yields
  function automatic queue_result_t apply_request(logic mode, logic signed [DATA_W-1:0] value);
    queue_result_t            r;
    logic signed [DATA_W-1:0] best;
    r.status    = ST_DONE;
    r.popped    = '0;
    r.max_value = '0;
    r.max_valid = 1'b0;
    r.count     = '0;
    if (mode == MODE_PUSH) begin
      if (!model_nonempty) begin
        model_head     = 0;
        model_tail     = 0;
        model_store[0] = value;
        model_nonempty = 1'b1;
      end else if (model_tail >= DEPTH - 1) begin
        r.status = ST_FULL;
      end else begin
        model_tail++;
        model_store[model_tail] = value;
      end
    end else begin
      if (!model_nonempty) begin
        r.status = ST_EMPTY;
      end else begin
        r.popped = model_store[model_head];
        if (model_head == model_tail) begin
          model_head     = 0;
          model_tail     = 0;
          model_nonempty = 1'b0;
        end else begin
          model_head++;
        end
      end
    end
    // Scan the held entries for the maximum
    if (model_nonempty) begin
      best = model_store[model_head];
      for (int i = model_head + 1; i <= model_tail; i++) begin
        if (model_store[i] > best) best = model_store[i];
      end
      r.max_value = best;
      r.max_valid = 1'b1;
      r.count     = COUNT_W'(model_tail - model_head + 1);
    end
    return r;
  endfunction

  function automatic logic signed [DATA_W-1:0] rand_value();
    case ($urandom_range(0, 9))
      0:       return 32'sh7FFF_FFFF;
      1:       return 32'sh8000_0000;
      2:       return $signed(DATA_W'($urandom_range(0, 15))) - 32'sd8;
      default: return $signed(DATA_W'($urandom));
    endcase
  endfunction

  task automatic add_req(logic mode, logic signed [DATA_W-1:0] value);
    queue_req_t r;
    r.mode  = mode;
    r.value = value;
    pending_reqs.push_back(r);
  endtask

  // Compare one result with the oldest expectation
  task automatic check_result();
    queue_result_t want;
    if (expected_results.size() == 0) begin
      mismatches++;
      if (mismatches <= SHOWN_ERRORS)
        $display("[%0t] unexpected result: status=%0d popped=%0d max=%0d valid=%0b count=%0d",
                 $time, rsp_ch.status, rsp_ch.popped_value, rsp_ch.max_value,
                 rsp_ch.max_valid, rsp_ch.entry_count);
    end else begin
      want = expected_results.pop_front();
      if (rsp_ch.status !== want.status || rsp_ch.popped_value !== want.popped ||
          rsp_ch.max_value !== want.max_value || rsp_ch.max_valid !== want.max_valid ||
          rsp_ch.entry_count !== want.count) begin
        mismatches++;
        if (mismatches <= SHOWN_ERRORS) begin
          $display("[%0t] result mismatch", $time);
          $display("  expected: status=%0d popped=%0d max=%0d valid=%0b count=%0d",
                   want.status, want.popped, want.max_value, want.max_valid, want.count);
          $display("  actual:   status=%0d popped=%0d max=%0d valid=%0b count=%0d",
                   rsp_ch.status, rsp_ch.popped_value, rsp_ch.max_value,
                   rsp_ch.max_valid, rsp_ch.entry_count);
        end
      end
    end
  endtask

  // Monitor both channels, predict on accept, watch for a hang
  always @(posedge clk) begin
    if (rst) begin
      req_taken   = 1'b0;
      idle_cycles = 0;
    end else begin
      req_taken = req_ch.valid && req_ch.ready;
      if (rsp_ch.valid && rsp_ch.ready) check_result();
      if (req_taken) begin
        expected_results.push_back(apply_request(req_ch.mode, req_ch.value));
        req_accepted++;
      end
      if (req_taken || (rsp_ch.valid && rsp_ch.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("[%0t] timeout: no item moved for %0d cycles", $time, IDLE_LIMIT);
        $display("FAIL");
        $finish;
      end
    end
  end

  // Drive requests from the pending queue, with random idle bursts
  always @(negedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else if (req_ch.valid && !req_taken) begin
      // hold the offered item
    end else if (send_gap > 0) begin
      req_ch.valid <= 1'b0;
      send_gap     <= send_gap - 1;
    end else if (pending_reqs.size() > QUIET_ITEMS && $urandom_range(0, 7) == 0) begin
      req_ch.valid <= 1'b0;
      send_gap     <= $urandom_range(0, 10);
    end else if (pending_reqs.size() != 0) begin
      next_req      = pending_reqs.pop_front();
      req_ch.valid <= 1'b1;
      req_ch.mode  <= next_req.mode;
      req_ch.value <= next_req.value;
    end else begin
      req_ch.valid <= 1'b0;
    end
  end

  // Drive result ready: one long hold to back up the block, then random stalls
  always @(negedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      rsp_ch.ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else if (!hold_done && req_accepted >= PRESSURE_AT) begin
      rsp_ch.ready <= 1'b0;
      hold_left    <= HOLD_CYCLES - 1;
      hold_done    <= 1'b1;
    end else if (stall_left > 0) begin
      rsp_ch.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else if (pending_reqs.size() > QUIET_ITEMS && $urandom_range(0, 7) == 0) begin
      rsp_ch.ready <= 1'b0;
      stall_left   <= $urandom_range(0, 10);
    end else begin
      rsp_ch.ready <= 1'b1;
    end
  end

  initial begin
    req_ch.valid = 1'b0;
    req_ch.mode  = MODE_PUSH;
    req_ch.value = '0;
    rsp_ch.ready = 1'b0;

    // Directed: pop when empty, field extremes, drain past empty
    add_req(MODE_POP, 32'sh1234_5678);
    add_req(MODE_PUSH, 32'sh7FFF_FFFF);
    add_req(MODE_PUSH, 32'sh8000_0000);
    add_req(MODE_PUSH, -32'sd1);
    add_req(MODE_PUSH, 32'sd0);
    add_req(MODE_PUSH, 32'sd1);
    repeat (6) add_req(MODE_POP, rand_value());
    // single most negative entry, then equal entries
    add_req(MODE_PUSH, 32'sh8000_0000);
    add_req(MODE_POP, 32'sh7FFF_FFFF);
    add_req(MODE_PUSH, -32'sd1);
    add_req(MODE_PUSH, -32'sd1);
    add_req(MODE_PUSH, 32'sh5555_5555);
    add_req(MODE_PUSH, 32'shAAAA_AAAA);
    repeat (5) add_req(MODE_POP, rand_value());

    // Random walk biased toward pushes
    repeat (100) add_req(($urandom_range(0, 9) < 6) ? MODE_PUSH : MODE_POP, rand_value());
    // Drain to empty and beyond
    repeat (110) add_req(MODE_POP, rand_value());
    // Fill to the last slot, then push against a full queue
    repeat (DEPTH + 4) add_req(MODE_PUSH, rand_value());
    // Free the front; the linear queue must still refuse pushes
    repeat (30) add_req(MODE_POP, rand_value());
    repeat (8) add_req(MODE_PUSH, rand_value());
    // Drain again so pushes restart at slot 0
    repeat (DEPTH - 30 + 7) add_req(MODE_POP, rand_value());
    repeat (QUIET_ITEMS + 10)
      add_req(($urandom_range(0, 9) < 6) ? MODE_PUSH : MODE_POP, rand_value());

    // Release reset once
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Wait for all items to be taken and all results to arrive
    while (pending_reqs.size() != 0 || req_ch.valid) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    mismatches += expected_results.size();
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

@@ linear_queue_with_max_query.f @@
rtl/lqmq_pkg.sv
rtl/lqmq_if.sv
rtl/lqmq_ram.sv
rtl/lqmq_ctrl.sv
rtl/lqmq_dp.sv
rtl/linear_queue_with_max_query.sv
tb/tb.sv
